### rtl/rbs_pkg.sv
// Shared types, widths, register indexes and helpers for the ray versus box slab test.
// Used by every module of the block; depends on nothing else.
package rbs_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int NUM_AXES = 3;
  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + COORD_W;
  localparam int PT_PROD_W = 2 * COORD_W;
  localparam int WIDE_W = PROD_W + 1;
  localparam int CFG_ADDR_W = 3;
  localparam int NUM_STAGES = 6;

  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BOX_MAX_Z = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;

  localparam coord_t T_MIN = 32'sh8000_0000;
  localparam coord_t T_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic diff;
    logic prod;
    logic order;
  } rbs_slab_en_t;

  typedef struct packed {
    logic prod;
    logic sum;
  } rbs_point_en_t;

  function automatic coord_t sat32(input logic signed [WIDE_W-1:0] v);
    logic [WIDE_W-COORD_W:0] upper;
    coord_t res;
    upper = v[WIDE_W-1:COORD_W-1];
    if (!v[WIDE_W-1] && (|upper)) begin
      res = T_MAX;
    end else if (v[WIDE_W-1] && !(&upper)) begin
      res = T_MIN;
    end else begin
      res = v[COORD_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/rbs_slab_lane.sv
// One axis lane: slab differences, distance products, shift, clamp and ordering.
// Depends on rbs_pkg for widths, the clamp helper and the stage enable struct.
module rbs_slab_lane (
  input  logic                 clk,
  input  rbs_pkg::rbs_slab_en_t en,
  input  rbs_pkg::coord_t      org,
  input  rbs_pkg::coord_t      dir,
  input  rbs_pkg::coord_t      inv,
  input  rbs_pkg::coord_t      lo,
  input  rbs_pkg::coord_t      hi,
  output rbs_pkg::coord_t      t_lo,
  output rbs_pkg::coord_t      t_hi,
  output logic                 skip,
  output logic                 miss,
  output rbs_pkg::coord_t      org_o,
  output rbs_pkg::coord_t      dir_o
);

  logic signed [rbs_pkg::DIFF_W-1:0] dlo_r, dhi_r;
  rbs_pkg::coord_t inv_r;
  rbs_pkg::coord_t org1_r, dir1_r, org2_r, dir2_r, org3_r, dir3_r;
  logic zero1_r, miss1_r, zero2_r, miss2_r, zero3_r, miss3_r;
  logic signed [rbs_pkg::PROD_W-1:0] plo_r, phi_r;
  logic signed [rbs_pkg::PROD_W-1:0] sh_lo, sh_hi;
  rbs_pkg::coord_t t1, t2;
  rbs_pkg::coord_t tlo_r, thi_r;

  always_ff @(posedge clk) begin
    if (en.diff) begin
      dlo_r   <= {lo[rbs_pkg::COORD_W-1], lo} - {org[rbs_pkg::COORD_W-1], org};
      dhi_r   <= {hi[rbs_pkg::COORD_W-1], hi} - {org[rbs_pkg::COORD_W-1], org};
      inv_r   <= inv;
      zero1_r <= (dir == '0);
      miss1_r <= (dir == '0) && ((org < lo) || (org > hi));
      org1_r  <= org;
      dir1_r  <= dir;
    end
  end

  always_ff @(posedge clk) begin
    if (en.prod) begin
      plo_r   <= dlo_r * inv_r;
      phi_r   <= dhi_r * inv_r;
      zero2_r <= zero1_r;
      miss2_r <= miss1_r;
      org2_r  <= org1_r;
      dir2_r  <= dir1_r;
    end
  end

  always_comb begin
    sh_lo = plo_r >>> rbs_pkg::COORD_FRAC_BITS;
    sh_hi = phi_r >>> rbs_pkg::COORD_FRAC_BITS;
    t1 = rbs_pkg::sat32(rbs_pkg::WIDE_W'(sh_lo));
    t2 = rbs_pkg::sat32(rbs_pkg::WIDE_W'(sh_hi));
  end

  always_ff @(posedge clk) begin
    if (en.order) begin
      tlo_r   <= (t1 < t2) ? t1 : t2;
      thi_r   <= (t1 < t2) ? t2 : t1;
      zero3_r <= zero2_r;
      miss3_r <= miss2_r;
      org3_r  <= org2_r;
      dir3_r  <= dir2_r;
    end
  end

  assign t_lo  = tlo_r;
  assign t_hi  = thi_r;
  assign skip  = zero3_r;
  assign miss  = miss3_r;
  assign org_o = org3_r;
  assign dir_o = dir3_r;

endmodule

### rtl/rbs_merge.sv
// Merge stage: combines the lane distances into entry and exit and decides hit or miss.
// Depends on rbs_pkg for the coordinate type and the interval limits.
module rbs_merge (
  input  logic            clk,
  input  logic            en,
  input  rbs_pkg::coord_t t_lo [rbs_pkg::NUM_AXES],
  input  rbs_pkg::coord_t t_hi [rbs_pkg::NUM_AXES],
  input  logic            skip [rbs_pkg::NUM_AXES],
  input  logic            miss [rbs_pkg::NUM_AXES],
  input  rbs_pkg::coord_t org  [rbs_pkg::NUM_AXES],
  input  rbs_pkg::coord_t dir  [rbs_pkg::NUM_AXES],
  output rbs_pkg::coord_t t_near,
  output rbs_pkg::coord_t t_far,
  output logic            hit,
  output rbs_pkg::coord_t org_o [rbs_pkg::NUM_AXES],
  output rbs_pkg::coord_t dir_o [rbs_pkg::NUM_AXES]
);

  rbs_pkg::coord_t near_c, far_c;
  logic miss_c;
  rbs_pkg::coord_t near_r, far_r;
  logic hit_r;
  rbs_pkg::coord_t org_r [rbs_pkg::NUM_AXES];
  rbs_pkg::coord_t dir_r [rbs_pkg::NUM_AXES];

  always_comb begin
    near_c = rbs_pkg::T_MIN;
    far_c  = rbs_pkg::T_MAX;
    miss_c = 1'b0;
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      if (miss[a]) begin
        miss_c = 1'b1;
      end
      if (!skip[a]) begin
        if (t_lo[a] > near_c) begin
          near_c = t_lo[a];
        end
        if (t_hi[a] < far_c) begin
          far_c = t_hi[a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near_r <= near_c;
      far_r  <= far_c;
      hit_r  <= !miss_c && !(near_c > far_c) && !far_c[rbs_pkg::COORD_W-1];
      org_r  <= org;
      dir_r  <= dir;
    end
  end

  assign t_near = near_r;
  assign t_far  = far_r;
  assign hit    = hit_r;
  assign org_o  = org_r;
  assign dir_o  = dir_r;

endmodule

### rtl/rbs_point_lane.sv
// One axis lane for the hit points: distance times direction, shift, add origin, clamp; zero on a miss.
// Depends on rbs_pkg for widths, the clamp helper and the stage enable struct.
module rbs_point_lane (
  input  logic                  clk,
  input  rbs_pkg::rbs_point_en_t en,
  input  logic                  hit,
  input  rbs_pkg::coord_t       t_near,
  input  rbs_pkg::coord_t       t_far,
  input  rbs_pkg::coord_t       org,
  input  rbs_pkg::coord_t       dir,
  output rbs_pkg::coord_t       near_pt,
  output rbs_pkg::coord_t       far_pt
);

  logic signed [rbs_pkg::PT_PROD_W-1:0] pn_r, pf_r;
  logic signed [rbs_pkg::PT_PROD_W-1:0] sh_n, sh_f;
  logic signed [rbs_pkg::WIDE_W-1:0] sum_n, sum_f;
  rbs_pkg::coord_t org_r;
  rbs_pkg::coord_t near_r, far_r;

  always_ff @(posedge clk) begin
    if (en.prod) begin
      pn_r  <= t_near * dir;
      pf_r  <= t_far * dir;
      org_r <= org;
    end
  end

  always_comb begin
    sh_n  = pn_r >>> rbs_pkg::COORD_FRAC_BITS;
    sh_f  = pf_r >>> rbs_pkg::COORD_FRAC_BITS;
    sum_n = rbs_pkg::WIDE_W'(sh_n) + rbs_pkg::WIDE_W'(org_r);
    sum_f = rbs_pkg::WIDE_W'(sh_f) + rbs_pkg::WIDE_W'(org_r);
  end

  always_ff @(posedge clk) begin
    if (en.sum) begin
      near_r <= hit ? rbs_pkg::sat32(sum_n) : '0;
      far_r  <= hit ? rbs_pkg::sat32(sum_f) : '0;
    end
  end

  assign near_pt = near_r;
  assign far_pt  = far_r;

endmodule

### rtl/ray_box_slab_intersect.sv
// Ray versus axis-aligned box test by the slab method, three axis lanes and a merge stage.
// Stages in order: slab difference, product, ordering, merge, point product, point sum.
// Throughput is one ray per cycle unless the output stalls; multipliers are pipelined.
// A stalled output holds its stage; earlier stages with bubbles keep accepting beats.
// rst_n is synchronous and active low; it clears every stage valid and the box to zero.
// Depends on rbs_pkg, rbs_slab_lane, rbs_merge and rbs_point_lane.
module ray_box_slab_intersect (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, inv_dir_x, inv_dir_y, inv_dir_z
  input  logic [287:0]                   in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // near_x, near_y, near_z, far_x, far_y, far_z
  output logic [191:0]                   out_tdata,
  // hit
  output logic [0:0]                     out_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rbs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [rbs_pkg::COORD_W-1:0]    cfg_data
);

  localparam int W = rbs_pkg::COORD_W;
  localparam int NA = rbs_pkg::NUM_AXES;

  rbs_pkg::coord_t box_min_r [NA];
  rbs_pkg::coord_t box_max_r [NA];
  logic [rbs_pkg::NUM_STAGES-1:0] v_r;
  logic [rbs_pkg::NUM_STAGES:0] en;

  rbs_pkg::coord_t org_in [NA];
  rbs_pkg::coord_t dir_in [NA];
  rbs_pkg::coord_t inv_in [NA];

  rbs_pkg::coord_t t_lo [NA];
  rbs_pkg::coord_t t_hi [NA];
  logic skip [NA];
  logic miss [NA];
  rbs_pkg::coord_t org_s3 [NA];
  rbs_pkg::coord_t dir_s3 [NA];

  rbs_pkg::coord_t t_near, t_far;
  logic hit_s4;
  logic hit5_r, hit6_r;
  rbs_pkg::coord_t org_s4 [NA];
  rbs_pkg::coord_t dir_s4 [NA];

  rbs_pkg::coord_t near_pt [NA];
  rbs_pkg::coord_t far_pt [NA];

  rbs_pkg::rbs_slab_en_t slab_en;
  rbs_pkg::rbs_point_en_t point_en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < NA; a++) begin
        box_min_r[a] <= '0;
        box_max_r[a] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        rbs_pkg::REG_BOX_MIN_X: box_min_r[0] <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Y: box_min_r[1] <= cfg_data;
        rbs_pkg::REG_BOX_MIN_Z: box_min_r[2] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_X: box_max_r[0] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Y: box_max_r[1] <= cfg_data;
        rbs_pkg::REG_BOX_MAX_Z: box_max_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    en[rbs_pkg::NUM_STAGES] = out_tready;
    for (int k = rbs_pkg::NUM_STAGES - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_tvalid;
      end
      for (int k = 1; k < rbs_pkg::NUM_STAGES; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_tready = en[0];
  assign out_tvalid = v_r[rbs_pkg::NUM_STAGES-1];

  assign slab_en.diff = en[0];
  assign slab_en.prod = en[1];
  assign slab_en.order = en[2];
  assign point_en.prod = en[4];
  assign point_en.sum = en[5];

  always_ff @(posedge clk) begin
    if (en[4]) begin
      hit5_r <= hit_s4;
    end
    if (en[5]) begin
      hit6_r <= hit5_r;
    end
  end

  for (genvar a = 0; a < NA; a++) begin : g_lane
    assign org_in[a] = in_tdata[a*W +: W];
    assign dir_in[a] = in_tdata[(NA+a)*W +: W];
    assign inv_in[a] = in_tdata[(2*NA+a)*W +: W];

    rbs_slab_lane u_slab (
      .clk   (clk),
      .en    (slab_en),
      .org   (org_in[a]),
      .dir   (dir_in[a]),
      .inv   (inv_in[a]),
      .lo    (box_min_r[a]),
      .hi    (box_max_r[a]),
      .t_lo  (t_lo[a]),
      .t_hi  (t_hi[a]),
      .skip  (skip[a]),
      .miss  (miss[a]),
      .org_o (org_s3[a]),
      .dir_o (dir_s3[a])
    );

    rbs_point_lane u_point (
      .clk     (clk),
      .en      (point_en),
      .hit     (hit5_r),
      .t_near  (t_near),
      .t_far   (t_far),
      .org     (org_s4[a]),
      .dir     (dir_s4[a]),
      .near_pt (near_pt[a]),
      .far_pt  (far_pt[a])
    );

    assign out_tdata[a*W +: W] = near_pt[a];
    assign out_tdata[(NA+a)*W +: W] = far_pt[a];
  end

  rbs_merge u_merge (
    .clk    (clk),
    .en     (en[3]),
    .t_lo   (t_lo),
    .t_hi   (t_hi),
    .skip   (skip),
    .miss   (miss),
    .org    (org_s3),
    .dir    (dir_s3),
    .t_near (t_near),
    .t_far  (t_far),
    .hit    (hit_s4),
    .org_o  (org_s4),
    .dir_o  (dir_s4)
  );

  assign out_tuser[0] = hit6_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata == '0))
    else $error("miss result carries nonzero points");

  a_hit_order: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && hit_s4) |-> (!(t_near > t_far) && !t_far[W-1]))
    else $error("hit with empty or negative interval");

  a_bubble_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (!v_r[0] || !out_tvalid) |-> in_tready)
    else $error("input stalled although the pipeline has room");

endmodule

### tb/ray_box_slab_intersect_test.sv
// Self-checking testbench for ray_box_slab_intersect: directed and random rays against the reset box and
// boxes loaded over the cfg channel, each result beat compared with a table entry or a built-in slab-test predictor.
// Depends on rbs_pkg and the ray_box_slab_intersect RTL.
`timescale 1ns / 1ps

module ray_box_slab_intersect_test;

  localparam int PIPE_DEPTH = 6;
  localparam int DRAIN_CYCLES = PIPE_DEPTH + 4;
  localparam int HOLD_CYCLES = 300;
  localparam int BOXED_FROM = 3;
  localparam int NUM_PROBES = 19;
  localparam longint RECIP_ONE = 64'sh1_0000_0000;

  localparam logic [rbs_pkg::CFG_ADDR_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [rbs_pkg::CFG_ADDR_W-1:0] REG_SPARE_HI = 3'd7;

  localparam rbs_pkg::coord_t ONE = 32'sh0001_0000;
  localparam rbs_pkg::coord_t HALF = 32'sh0000_8000;
  localparam rbs_pkg::coord_t TWO = 32'sh0002_0000;
  localparam rbs_pkg::coord_t THREE = 32'sh0003_0000;
  localparam rbs_pkg::coord_t FIVE = 32'sh0005_0000;
  localparam rbs_pkg::coord_t LSB = 32'sh0000_0001;
  localparam rbs_pkg::coord_t ALL_ONES = 32'shffff_ffff;

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    rbs_pkg::coord_t [2:0] inv;
    rbs_pkg::coord_t [2:0] dir;
    rbs_pkg::coord_t [2:0] org;
  } ray_t;

  typedef struct packed {
    logic                  hit;
    rbs_pkg::coord_t [2:0] far_pt;
    rbs_pkg::coord_t [2:0] near_pt;
  } hit_result_t;

  typedef struct packed {
    logic        typed;
    hit_result_t want;
    ray_t        r;
  } probe_t;

  typedef enum int {BOX_ORDERED, BOX_INVERTED, BOX_FLAT, BOX_RAW} box_shape_t;

  localparam hit_result_t NO_HIT = '0;

  function automatic ray_t mk_ray(input rbs_pkg::coord_t ox, oy, oz, dx, dy, dz, ix, iy, iz);
    ray_t r;
    r.org[0] = ox; r.org[1] = oy; r.org[2] = oz;
    r.dir[0] = dx; r.dir[1] = dy; r.dir[2] = dz;
    r.inv[0] = ix; r.inv[1] = iy; r.inv[2] = iz;
    return r;
  endfunction

  function automatic hit_result_t mk_hit(input logic h,
                                         input rbs_pkg::coord_t nx, ny, nz, fx, fy, fz);
    hit_result_t res;
    res.hit = h;
    res.near_pt[0] = nx; res.near_pt[1] = ny; res.near_pt[2] = nz;
    res.far_pt[0] = fx; res.far_pt[1] = fy; res.far_pt[2] = fz;
    return res;
  endfunction

  // Rows before BOXED_FROM run against the all-zero box left by reset.
  localparam probe_t PROBES [NUM_PROBES] = '{
    '{1'b1, mk_hit(1'b1, 0, 0, 0, 0, 0, 0), mk_ray(0, 0, 0, 0, 0, 0, 0, 0, 0)},
    '{1'b1, NO_HIT, mk_ray(ONE, 0, 0, 0, 0, 0, 0, 0, 0)},
    '{1'b1, mk_hit(1'b1, 0, 0, 0, 0, 0, 0), mk_ray(0, 0, 0, ONE, 0, 0, ONE, 0, 0)},
    '{1'b1, mk_hit(1'b1, HALF, ONE, -HALF, HALF, ONE, -HALF),
      mk_ray(HALF, ONE, -HALF, 0, 0, 0, ALL_ONES, ALL_ONES, ALL_ONES)},
    '{1'b1, NO_HIT, mk_ray(0, THREE, 0, 0, 0, 0, 0, 0, 0)},
    '{1'b1, NO_HIT, mk_ray(-TWO, 0, 0, 0, ONE, ONE, 0, ONE, ONE)},
    '{1'b0, NO_HIT, mk_ray(-TWO, 0, 0, ONE, 0, 0, ONE, 0, 0)},
    '{1'b1, NO_HIT, mk_ray(TWO, 0, 0, ONE, 0, 0, ONE, 0, 0)},
    '{1'b0, NO_HIT, mk_ray(TWO, 0, 0, -ONE, 0, 0, -ONE, 0, 0)},
    '{1'b0, NO_HIT, mk_ray(0, 0, 0, ONE, ONE, ONE, ONE, ONE, ONE)},
    '{1'b1, NO_HIT, mk_ray(-TWO, -FIVE, 0, ONE, ONE, 0, ONE, ONE, 0)},
    '{1'b0, NO_HIT, mk_ray(rbs_pkg::T_MIN, 0, 0, ONE, 0, 0, rbs_pkg::T_MAX, 0, 0)},
    '{1'b0, NO_HIT, mk_ray(rbs_pkg::T_MAX, rbs_pkg::T_MAX, rbs_pkg::T_MAX,
                           rbs_pkg::T_MIN, rbs_pkg::T_MIN, rbs_pkg::T_MIN,
                           rbs_pkg::T_MIN, rbs_pkg::T_MIN, rbs_pkg::T_MIN)},
    '{1'b0, NO_HIT, mk_ray(rbs_pkg::T_MIN, rbs_pkg::T_MIN, rbs_pkg::T_MIN,
                           rbs_pkg::T_MAX, rbs_pkg::T_MAX, rbs_pkg::T_MAX,
                           rbs_pkg::T_MAX, rbs_pkg::T_MAX, rbs_pkg::T_MAX)},
    '{1'b0, NO_HIT, mk_ray(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
                           ALL_ONES, ALL_ONES, ALL_ONES)},
    '{1'b0, NO_HIT, mk_ray(-TWO, 0, 0, LSB, 0, 0, rbs_pkg::T_MAX, 0, 0)},
    '{1'b0, NO_HIT, mk_ray(0, 0, 0, -HALF, HALF, ONE, -TWO, TWO, ONE)},
    '{1'b0, NO_HIT, mk_ray(-ONE, 0, 0, ONE, 0, 0, ONE, 0, 0)},
    '{1'b0, NO_HIT, mk_ray(-TWO, -TWO, -TWO, ONE, ONE, ONE, ONE, ONE, ONE)}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [287:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [191:0] out_tdata;
  logic [0:0] out_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [rbs_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [rbs_pkg::COORD_W-1:0] cfg_data;

  rbs_pkg::coord_t box_lo [3];
  rbs_pkg::coord_t box_hi [3];
  hit_result_t pending_hits [$];
  int mismatches = 0;
  bit gaps_on = 1'b0;
  bit stalls_on = 1'b0;
  bit hold_req = 1'b0;

  ray_box_slab_intersect dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr(cfg_addr),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic rbs_pkg::coord_t fit_coord(input wide_t v);
    if (v > rbs_pkg::T_MAX) begin
      return rbs_pkg::T_MAX;
    end else if (v < rbs_pkg::T_MIN) begin
      return rbs_pkg::T_MIN;
    end
    return rbs_pkg::coord_t'(v[31:0]);
  endfunction

  // Slab test: per-axis entry and exit distances, then entry and exit points on a hit.
  function automatic hit_result_t intersect_ray(input ray_t r);
    wide_t o_w, d_w, inv_w, span_lo, span_hi, tn_w, tf_w;
    rbs_pkg::coord_t t1, t2, tmp, t_near, t_far;
    logic hit;
    hit_result_t res;
    t_near = rbs_pkg::T_MIN;
    t_far = rbs_pkg::T_MAX;
    hit = 1'b1;
    res = '0;
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      o_w = $signed(r.org[a]);
      if (r.dir[a] == 0) begin
        if ($signed(r.org[a]) < box_lo[a] || $signed(r.org[a]) > box_hi[a]) hit = 1'b0;
      end else begin
        inv_w = $signed(r.inv[a]);
        span_lo = box_lo[a];
        span_hi = box_hi[a];
        t1 = fit_coord(((span_lo - o_w) * inv_w) >>> rbs_pkg::COORD_FRAC_BITS);
        t2 = fit_coord(((span_hi - o_w) * inv_w) >>> rbs_pkg::COORD_FRAC_BITS);
        if (t1 > t2) begin
          tmp = t1;
          t1 = t2;
          t2 = tmp;
        end
        if (t1 > t_near) t_near = t1;
        if (t2 < t_far) t_far = t2;
      end
    end
    if (t_near > t_far || t_far < 0) hit = 1'b0;
    if (hit) begin
      res.hit = 1'b1;
      tn_w = t_near;
      tf_w = t_far;
      for (int j = 0; j < rbs_pkg::NUM_AXES; j++) begin
        o_w = $signed(r.org[j]);
        d_w = $signed(r.dir[j]);
        res.near_pt[j] = fit_coord(o_w + ((tn_w * d_w) >>> rbs_pkg::COORD_FRAC_BITS));
        res.far_pt[j] = fit_coord(o_w + ((tf_w * d_w) >>> rbs_pkg::COORD_FRAC_BITS));
      end
    end
    return res;
  endfunction

  function automatic rbs_pkg::coord_t pick_extreme();
    case ($urandom_range(0, 3))
      0: return rbs_pkg::T_MIN;
      1: return rbs_pkg::T_MAX;
      2: return ALL_ONES;
      default: return 0;
    endcase
  endfunction

  // Shaped rays aim at a random point inside the current box; the rest are noise.
  function automatic ray_t gen_ray(input bit shaped);
    ray_t r;
    longint lo_l, hi_l, tmp, tgt, org, step;
    rbs_pkg::coord_t d;
    int sh;
    sh = $urandom_range(0, 3);
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      if (shaped) begin
        lo_l = box_lo[a];
        hi_l = box_hi[a];
        if (lo_l > hi_l) begin
          tmp = lo_l;
          lo_l = hi_l;
          hi_l = tmp;
        end
        tgt = lo_l + longint'($urandom) % (hi_l - lo_l + 1);
        if ($urandom_range(0, 7) == 0) begin
          org = tgt;
        end else begin
          org = tgt + longint'($urandom_range(0, 32'h01ff_ffff)) - 64'sd16777216;
        end
        r.org[a] = fit_coord(org);
        step = tgt - longint'($signed(r.org[a]));
        d = fit_coord(step >>> sh);
        r.dir[a] = d;
        r.inv[a] = (d == 0) ? rbs_pkg::coord_t'($urandom)
                            : fit_coord(RECIP_ONE / longint'($signed(d)));
      end else begin
        r.org[a] = ($urandom_range(0, 5) == 0) ? pick_extreme()
                                               : rbs_pkg::coord_t'($urandom);
        r.dir[a] = ($urandom_range(0, 4) == 0) ? rbs_pkg::coord_t'(0)
                                               : rbs_pkg::coord_t'($urandom);
        r.inv[a] = ($urandom_range(0, 5) == 0) ? pick_extreme()
                                               : rbs_pkg::coord_t'($urandom);
      end
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input logic [31:0] got_v,
                               input logic [31:0] want_v);
    $display("mismatch on %s: got %h, expected %h, at %0t", what, got_v, want_v, $time);
    mismatches++;
  endtask

  task automatic cfg_write(input logic [rbs_pkg::CFG_ADDR_W-1:0] addr,
                           input rbs_pkg::coord_t data);
    cfg_valid <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (addr)
      rbs_pkg::REG_BOX_MIN_X: box_lo[0] = data;
      rbs_pkg::REG_BOX_MIN_Y: box_lo[1] = data;
      rbs_pkg::REG_BOX_MIN_Z: box_lo[2] = data;
      rbs_pkg::REG_BOX_MAX_X: box_hi[0] = data;
      rbs_pkg::REG_BOX_MAX_Y: box_hi[1] = data;
      rbs_pkg::REG_BOX_MAX_Z: box_hi[2] = data;
      default: ;
    endcase
  endtask

  // A write to an unused index rides along each time and must leave the box alone.
  task automatic load_box(input rbs_pkg::coord_t [2:0] lo, input rbs_pkg::coord_t [2:0] hi);
    cfg_write(rbs_pkg::REG_BOX_MIN_X, lo[0]);
    cfg_write(rbs_pkg::REG_BOX_MIN_Y, lo[1]);
    cfg_write(rbs_pkg::REG_BOX_MIN_Z, lo[2]);
    cfg_write($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
              rbs_pkg::coord_t'($urandom));
    cfg_write(rbs_pkg::REG_BOX_MAX_X, hi[0]);
    cfg_write(rbs_pkg::REG_BOX_MAX_Y, hi[1]);
    cfg_write(rbs_pkg::REG_BOX_MAX_Z, hi[2]);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_random_box(input int span, input box_shape_t shape);
    rbs_pkg::coord_t [2:0] lo, hi;
    int p, q;
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      p = $urandom_range(0, 2 * span) - span;
      q = $urandom_range(0, 2 * span) - span;
      case (shape)
        BOX_ORDERED: begin
          lo[a] = (p < q) ? p : q;
          hi[a] = (p < q) ? q : p;
        end
        BOX_INVERTED: begin
          lo[a] = ((p < q) ? q : p) + 1;
          hi[a] = (p < q) ? p : q;
        end
        BOX_FLAT: begin
          lo[a] = p;
          hi[a] = p;
        end
        default: begin
          lo[a] = $urandom;
          hi[a] = $urandom;
        end
      endcase
    end
    load_box(lo, hi);
  endtask

  task automatic send_ray(input ray_t r, input hit_result_t want);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= r;
    do @(posedge clk); while (!in_tready);
    pending_hits.push_back(want);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_batch(input int count);
    ray_t r;
    for (int i = 0; i < count; i++) begin
      r = gen_ray($urandom_range(0, 9) < 8);
      send_ray(r, intersect_ray(r));
    end
    drain();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    cfg_valid <= 1'b0;
    cfg_addr <= '0;
    cfg_data <= '0;
    for (int a = 0; a < rbs_pkg::NUM_AXES; a++) begin
      box_lo[a] = 0;
      box_hi[a] = 0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gaps_on = 1'b1;
    stalls_on = 1'b1;
    for (int i = 0; i < NUM_PROBES; i++) begin
      if (i == BOXED_FROM) begin
        drain();
        load_box({-ONE, -ONE, -ONE}, {ONE, TWO, ONE});
      end
      send_ray(PROBES[i].r, PROBES[i].typed ? PROBES[i].want : intersect_ray(PROBES[i].r));
    end
    drain();

    load_random_box(32'h0064_0000, BOX_ORDERED);
    run_batch(200);

    // The receiver holds off while beats keep coming, so the pipeline backs up.
    gaps_on = 1'b0;
    load_box({rbs_pkg::T_MIN, rbs_pkg::T_MIN, rbs_pkg::T_MIN},
             {rbs_pkg::T_MAX, rbs_pkg::T_MAX, rbs_pkg::T_MAX});
    hold_req = 1'b1;
    run_batch(150);
    gaps_on = 1'b1;

    load_random_box(32'h0064_0000, BOX_INVERTED);
    run_batch(150);
    load_random_box(32'h0010_0000, BOX_FLAT);
    run_batch(150);
    load_random_box(0, BOX_RAW);
    run_batch(150);

    gaps_on = 1'b0;
    stalls_on = 1'b0;
    load_random_box(32'h0064_0000, BOX_ORDERED);
    run_batch(250);

    if (mismatches == 0) begin
      $display("ray_box_slab_intersect_test: PASS");
    end else begin
      $display("ray_box_slab_intersect_test: FAIL");
    end
    $finish;
  end

  initial begin
    out_tready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin : result_check
    hit_result_t got;
    hit_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tuser[0], out_tdata};
      if (pending_hits.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding", 32'(got.hit), 32'd0);
      end else begin
        want = pending_hits.pop_front();
        if (got.hit !== want.hit) flag_mismatch("hit", 32'(got.hit), 32'(want.hit));
        for (int j = 0; j < rbs_pkg::NUM_AXES; j++) begin
          if (got.near_pt[j] !== want.near_pt[j]) begin
            flag_mismatch($sformatf("near[%0d]", j), got.near_pt[j], want.near_pt[j]);
          end
          if (got.far_pt[j] !== want.far_pt[j]) begin
            flag_mismatch($sformatf("far[%0d]", j), got.far_pt[j], want.far_pt[j]);
          end
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("ray_box_slab_intersect_test: FAIL");
    $finish;
  end

endmodule
